@@ rtl/core/vpcs_pkg.sv @@
// Package for the 3D patch center scan: widths, register indexes, result kinds,
// shared structs and the saturating run step. No dependencies.
`timescale 1ns / 1ps

package vpcs_pkg;

   localparam int MAX_DIM   = 256;
   localparam int COORD_W   = $clog2(MAX_DIM);
   localparam int SIZE_W    = COORD_W + 1;
   localparam int PLANE_AW  = 2 * COORD_W;
   localparam int HALF_W    = 3;
   localparam int RUN_W     = HALF_W + 1;
   localparam int VOXEL_W   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE = 3'd6;

   localparam logic KIND_CENTER = 1'b0;
   localparam logic KIND_END    = 1'b1;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               last_x;
      logic               last_y;
      logic               last_z;
   } pos_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               src;
      logic               vol_end;
      logic               fwd_col;
      logic [RUN_W-1:0]   fwd_col_val;
      logic               fwd_pl;
      logic [RUN_W-1:0]   fwd_pl_val;
   } item_type;

   typedef struct packed {
      logic [RUN_W-1:0] run_x;
      logic [RUN_W-1:0] col;
      logic [RUN_W-1:0] plane;
      logic             hit;
   } runs_type;

   function automatic logic [RUN_W-1:0] bump(input logic [RUN_W-1:0] prev,
                                             input logic [RUN_W-1:0] full);
      logic [RUN_W:0] n;
      n = {1'b0, prev} + {{RUN_W{1'b0}}, 1'b1};
      return (n > {1'b0, full}) ? full : n[RUN_W-1:0];
   endfunction

endpackage

@@ rtl/core/vpcs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module vpcs_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/core/vpcs_scan.sv @@
// Raster position counter (x fastest) with clamped volume extents.
// Depends on vpcs_pkg.
`timescale 1ns / 1ps

module vpcs_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [vpcs_pkg::SIZE_W-1:0]   size_x,
   input  logic [vpcs_pkg::SIZE_W-1:0]   size_y,
   input  logic [vpcs_pkg::SIZE_W-1:0]   size_z,
   output vpcs_pkg::pos_type             pos
);

   logic [vpcs_pkg::COORD_W-1:0] x_ff, y_ff, z_ff;
   logic [vpcs_pkg::COORD_W-1:0] x_in, y_in, z_in;
   logic [vpcs_pkg::SIZE_W-1:0]  sx, sy, sz;

   function automatic logic [vpcs_pkg::SIZE_W-1:0] eff_size(
      input logic [vpcs_pkg::SIZE_W-1:0] s);
      if (s == '0) begin
         return {{(vpcs_pkg::SIZE_W-1){1'b0}}, 1'b1};
      end
      if (s > vpcs_pkg::SIZE_W'(vpcs_pkg::MAX_DIM)) begin
         return vpcs_pkg::SIZE_W'(vpcs_pkg::MAX_DIM);
      end
      return s;
   endfunction

   always_comb begin
      sx = eff_size(size_x);
      sy = eff_size(size_y);
      sz = eff_size(size_z);
      pos.x = x_ff;
      pos.y = y_ff;
      pos.z = z_ff;
      pos.last_x = ({1'b0, x_ff} + 1'b1) >= sx;
      pos.last_y = ({1'b0, y_ff} + 1'b1) >= sy;
      pos.last_z = ({1'b0, z_ff} + 1'b1) >= sz;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (pos.last_x) begin
         x_in = '0;
         if (pos.last_y) begin
            y_in = '0;
            z_in = pos.last_z ? '0 : z_ff + 1'b1;
         end else begin
            y_in = y_ff + 1'b1;
         end
      end else begin
         x_in = x_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
         z_ff <= '0;
      end else if (advance) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

endmodule

@@ rtl/core/vpcs_erode.sv @@
// Separable erosion step: x run, column run and plane run for one voxel.
// Depends on vpcs_pkg.
`timescale 1ns / 1ps

module vpcs_erode (
   input  vpcs_pkg::item_type             item,
   input  logic [vpcs_pkg::RUN_W-1:0]     run_x_prev,
   input  logic [vpcs_pkg::RUN_W-1:0]     col_rd,
   input  logic [vpcs_pkg::RUN_W-1:0]     plane_rd,
   input  logic [vpcs_pkg::HALF_W-1:0]    half_x,
   input  logic [vpcs_pkg::HALF_W-1:0]    half_y,
   input  logic [vpcs_pkg::HALF_W-1:0]    half_z,
   output vpcs_pkg::runs_type             runs
);

   logic [vpcs_pkg::RUN_W-1:0] fx, fy, fz;
   logic [vpcs_pkg::RUN_W-1:0] col_old, plane_old;

   always_comb begin
      fx = {half_x, 1'b1};
      fy = {half_y, 1'b1};
      fz = {half_z, 1'b1};
      col_old   = item.fwd_col ? item.fwd_col_val : col_rd;
      plane_old = item.fwd_pl ? item.fwd_pl_val : plane_rd;

      runs.run_x = item.src ?
         vpcs_pkg::bump((item.x == '0) ? '0 : run_x_prev, fx) : '0;
      runs.col = (runs.run_x >= fx) ?
         vpcs_pkg::bump((item.y == '0) ? '0 : col_old, fy) : '0;
      runs.plane = (runs.col >= fy) ?
         vpcs_pkg::bump((item.z == '0) ? '0 : plane_old, fz) : '0;
      runs.hit = runs.plane >= fz;
   end

endmodule

@@ rtl/core/valid_patch_center_scan_3d.sv @@
// Top level of the 3D patch center scan: config registers, voxel stage,
// line and plane stores, result register. Depends on vpcs_pkg and all rtl/core modules.
`timescale 1ns / 1ps

// Accepts one mask voxel per cycle in raster order (x fastest) unless a pending result
// stalls req_ready, and emits the coordinates of every patch center whose full box of
// 2h+1 voxels per axis matches source_value, then an end marker carrying none_found
// after the last voxel. A voxel is registered in the voxel stage and its result then in
// the result register. The end voxel yields two results when it also completes a center.
// The line store (256 x 4) and plane store (65536 x 4) are read at acceptance and written
// as the voxel retires; a one-entry bypass covers back-to-back voxels on the same store
// entry. Configuration must be written only while idle; the block does not enforce it.
module valid_patch_center_scan_3d (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [vpcs_pkg::VOXEL_W-1:0]    req_voxel,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_kind,
   output logic [vpcs_pkg::COORD_W-1:0]    rsp_center_x,
   output logic [vpcs_pkg::COORD_W-1:0]    rsp_center_y,
   output logic [vpcs_pkg::COORD_W-1:0]    rsp_center_z,
   output logic                            rsp_none_found,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [vpcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vpcs_pkg::CSR_DAT_W-1:0]  csr_data
);

   logic [vpcs_pkg::SIZE_W-1:0]  size_x_ff, size_y_ff, size_z_ff;
   logic [vpcs_pkg::HALF_W-1:0]  half_x_ff, half_y_ff, half_z_ff;
   logic [vpcs_pkg::VOXEL_W-1:0] source_ff;

   vpcs_pkg::pos_type  pos;
   vpcs_pkg::item_type item_ff, item_in;
   vpcs_pkg::runs_type runs;
   logic               item_valid_ff;
   logic               phase_ff;
   logic               any_found_ff;
   logic [vpcs_pkg::RUN_W-1:0] run_x_ff;

   logic [vpcs_pkg::RUN_W-1:0] col_rd, plane_rd;

   logic accept, emit_hit, has_result, cur_final, load, retire;

   logic                         rsp_valid_ff;
   logic                         kind_ff, none_found_ff, last_ff;
   logic [vpcs_pkg::COORD_W-1:0] cx_ff, cy_ff, cz_ff;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= vpcs_pkg::SIZE_W'(vpcs_pkg::MAX_DIM);
         size_y_ff <= vpcs_pkg::SIZE_W'(vpcs_pkg::MAX_DIM);
         size_z_ff <= vpcs_pkg::SIZE_W'(vpcs_pkg::MAX_DIM);
         half_x_ff <= vpcs_pkg::HALF_W'(2);
         half_y_ff <= vpcs_pkg::HALF_W'(2);
         half_z_ff <= vpcs_pkg::HALF_W'(2);
         source_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            vpcs_pkg::CSR_SIZE_X: size_x_ff <= csr_data;
            vpcs_pkg::CSR_SIZE_Y: size_y_ff <= csr_data;
            vpcs_pkg::CSR_SIZE_Z: size_z_ff <= csr_data;
            vpcs_pkg::CSR_HALF_X: half_x_ff <= csr_data[vpcs_pkg::HALF_W-1:0];
            vpcs_pkg::CSR_HALF_Y: half_y_ff <= csr_data[vpcs_pkg::HALF_W-1:0];
            vpcs_pkg::CSR_HALF_Z: half_z_ff <= csr_data[vpcs_pkg::HALF_W-1:0];
            vpcs_pkg::CSR_SOURCE: source_ff <= csr_data[vpcs_pkg::VOXEL_W-1:0];
            default: ;
         endcase
      end
   end

   vpcs_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .size_x  (size_x_ff),
      .size_y  (size_y_ff),
      .size_z  (size_z_ff),
      .pos     (pos)
   );

   vpcs_ram #(.WIDTH(vpcs_pkg::RUN_W), .DEPTH(vpcs_pkg::MAX_DIM)) u_line (
      .clock   (clock),
      .wr_en   (retire),
      .wr_addr (item_ff.x),
      .wr_data (runs.col),
      .rd_en   (accept),
      .rd_addr (pos.x),
      .rd_data (col_rd)
   );

   vpcs_ram #(.WIDTH(vpcs_pkg::RUN_W), .DEPTH(vpcs_pkg::MAX_DIM * vpcs_pkg::MAX_DIM)) u_plane (
      .clock   (clock),
      .wr_en   (retire),
      .wr_addr ({item_ff.y, item_ff.x}),
      .wr_data (runs.plane),
      .rd_en   (accept),
      .rd_addr ({pos.y, pos.x}),
      .rd_data (plane_rd)
   );

   vpcs_erode u_erode (
      .item       (item_ff),
      .run_x_prev (run_x_ff),
      .col_rd     (col_rd),
      .plane_rd   (plane_rd),
      .half_x     (half_x_ff),
      .half_y     (half_y_ff),
      .half_z     (half_z_ff),
      .runs       (runs)
   );

   // voxel stage control
   always_comb begin
      emit_hit   = runs.hit && !phase_ff;
      has_result = item_valid_ff && (emit_hit || item_ff.vol_end);
      cur_final  = emit_hit ? !item_ff.vol_end : 1'b1;
      load       = has_result && (!rsp_valid_ff || rsp_ready);
      retire     = item_valid_ff && (!has_result || (load && cur_final));
      req_ready  = !item_valid_ff || retire;
      accept     = req_valid && req_ready;

      item_in.x           = pos.x;
      item_in.y           = pos.y;
      item_in.z           = pos.z;
      item_in.src         = req_voxel == source_ff;
      item_in.vol_end     = pos.last_x && pos.last_y && pos.last_z;
      // store entry written on this same edge: read data is stale
      item_in.fwd_col     = retire && (item_ff.x == pos.x);
      item_in.fwd_col_val = runs.col;
      item_in.fwd_pl      = retire && (item_ff.x == pos.x) && (item_ff.y == pos.y);
      item_in.fwd_pl_val  = runs.plane;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         phase_ff      <= 1'b0;
         any_found_ff  <= 1'b0;
         run_x_ff      <= '0;
      end else begin
         if (accept) begin
            item_valid_ff <= 1'b1;
         end else if (retire) begin
            item_valid_ff <= 1'b0;
         end
         if (retire) begin
            phase_ff <= 1'b0;
         end else if (load) begin
            phase_ff <= 1'b1;
         end
         if (retire) begin
            run_x_ff <= runs.run_x;
            if (item_ff.vol_end) begin
               any_found_ff <= 1'b0;
            end else if (runs.hit) begin
               any_found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (emit_hit) begin
            kind_ff       <= vpcs_pkg::KIND_CENTER;
            cx_ff         <= item_ff.x - vpcs_pkg::COORD_W'(half_x_ff);
            cy_ff         <= item_ff.y - vpcs_pkg::COORD_W'(half_y_ff);
            cz_ff         <= item_ff.z - vpcs_pkg::COORD_W'(half_z_ff);
            none_found_ff <= 1'b0;
         end else begin
            kind_ff       <= vpcs_pkg::KIND_END;
            cx_ff         <= '0;
            cy_ff         <= '0;
            cz_ff         <= '0;
            none_found_ff <= !(any_found_ff || runs.hit);
         end
         last_ff <= cur_final;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_center_x   = cx_ff;
   assign rsp_center_y   = cy_ff;
   assign rsp_center_z   = cz_ff;
   assign rsp_none_found = none_found_ff;
   assign rsp_last       = last_ff;

endmodule

@@ bench/valid_patch_center_scan_3d_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for valid_patch_center_scan_3d: streams mask volumes, predicts
// patch centers and end markers, and checks every result transfer in order.
// Depends on vpcs_pkg and the rtl/core sources.

module valid_patch_center_scan_3d_tb;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 100;
   localparam int DIM           = vpcs_pkg::MAX_DIM;

   typedef struct {
      logic                         kind;
      logic [vpcs_pkg::COORD_W-1:0] x;
      logic [vpcs_pkg::COORD_W-1:0] y;
      logic [vpcs_pkg::COORD_W-1:0] z;
      logic                         none_found;
      logic                         last;
   } scan_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [vpcs_pkg::VOXEL_W-1:0]     req_voxel = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic                             rsp_kind;
   logic [vpcs_pkg::COORD_W-1:0]     rsp_center_x;
   logic [vpcs_pkg::COORD_W-1:0]     rsp_center_y;
   logic [vpcs_pkg::COORD_W-1:0]     rsp_center_z;
   logic                             rsp_none_found;
   logic                             rsp_last;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [vpcs_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [vpcs_pkg::CSR_DAT_W-1:0]   csr_data = '0;

   // predictor copy of registers and scan state
   logic [8:0] size_x_reg = 9'd256;
   logic [8:0] size_y_reg = 9'd256;
   logic [8:0] size_z_reg = 9'd256;
   logic [2:0] half_x_reg = 3'd2;
   logic [2:0] half_y_reg = 3'd2;
   logic [2:0] half_z_reg = 3'd2;
   logic [7:0] source_reg = 8'd0;
   int         pos_x = 0;
   int         pos_y = 0;
   int         pos_z = 0;
   int         run_x = 0;
   int         column_runs [DIM];
   int         plane_runs [DIM*DIM];
   bit         any_found = 1'b0;
   bit         volume_done = 1'b0;

   scan_result_type center_queue [$];

   int fail_count  = 0;
   int items_sent  = 0;
   int cycle_count = 0;
   int stall_left  = 0;
   bit idle_on     = 1'b1;

   valid_patch_center_scan_3d uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_voxel      (req_voxel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_center_x   (rsp_center_x),
      .rsp_center_y   (rsp_center_y),
      .rsp_center_z   (rsp_center_z),
      .rsp_none_found (rsp_none_found),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout, %0d results outstanding", $time, center_queue.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int clamp_size(input logic [8:0] s);
      if (s == 9'd0)
         return 1;
      if (s > 9'd256)
         return DIM;
      return int'(s);
   endfunction

   function automatic int sat_inc(input int prev, input int full);
      return (prev + 1 > full) ? full : prev + 1;
   endfunction

   // advance the erosion runs by one voxel and queue the results it causes
   function void scan_voxel(input logic [7:0] v);
      int sx, sy, sz, hx, hy, hz, fx, fy, fz;
      int x, y, z, idx, col, pl;
      bit src, hit, vol_end;
      scan_result_type r;
      sx = clamp_size(size_x_reg);
      sy = clamp_size(size_y_reg);
      sz = clamp_size(size_z_reg);
      hx = half_x_reg;
      hy = half_y_reg;
      hz = half_z_reg;
      fx = 2 * hx + 1;
      fy = 2 * hy + 1;
      fz = 2 * hz + 1;
      x = pos_x % DIM;
      y = pos_y % DIM;
      z = pos_z;
      idx = y * DIM + x;
      src = (v == source_reg);
      run_x = src ? sat_inc((x == 0) ? 0 : run_x, fx) : 0;
      col = (run_x >= fx) ? sat_inc((y == 0) ? 0 : column_runs[x], fy) : 0;
      column_runs[x] = col;
      pl = (col >= fy) ? sat_inc((z == 0) ? 0 : plane_runs[idx], fz) : 0;
      plane_runs[idx] = pl;
      hit = (pl >= fz);
      vol_end = (x + 1 >= sx) && (y + 1 >= sy) && (z + 1 >= sz);
      if (hit) begin
         any_found = 1'b1;
         r.kind = vpcs_pkg::KIND_CENTER;
         r.x = 8'(x - hx);
         r.y = 8'(y - hy);
         r.z = 8'(z - hz);
         r.none_found = 1'b0;
         r.last = !vol_end;
         center_queue = {center_queue, r};
      end
      if (vol_end) begin
         r.kind = vpcs_pkg::KIND_END;
         r.x = '0;
         r.y = '0;
         r.z = '0;
         r.none_found = !any_found;
         r.last = 1'b1;
         center_queue = {center_queue, r};
         any_found = 1'b0;
         volume_done = 1'b1;
      end
      if (x + 1 >= sx) begin
         pos_x = 0;
         if (y + 1 >= sy) begin
            pos_y = 0;
            pos_z = (z + 1 >= sz) ? 0 : z + 1;
         end else begin
            pos_y = y + 1;
         end
      end else begin
         pos_x = x + 1;
      end
      pos_y = pos_y % DIM;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 65)
         return 0;
      if (r < 94)
         return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   function automatic logic [7:0] pick_voxel(input int density);
      if ($urandom_range(0, 99) < density)
         return source_reg;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [8:0] random_half_data();
      logic [8:0] d;
      d = 9'($urandom_range(0, 511));
      d[2:0] = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(3, 7)) : 3'($urandom_range(0, 2));
      return d;
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
         stall_left = pick_gap();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic check_field(input string what, input logic [8:0] want, input logic [8:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %0d actual %0d", $time, what, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      scan_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (center_queue.size() == 0) begin
            $display("%0t unexpected result: expected none actual kind %0d (%0d,%0d,%0d)",
                     $time, rsp_kind, rsp_center_x, rsp_center_y, rsp_center_z);
            fail_count++;
         end else begin
            want = center_queue.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("center_x", want.x, rsp_center_x);
            check_field("center_y", want.y, rsp_center_y);
            check_field("center_z", want.z, rsp_center_z);
            check_field("none_found", want.none_found, rsp_none_found);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   task send_voxel(input logic [7:0] v);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_voxel <= v;
      do @(posedge clock); while (!req_ready);
      scan_voxel(v);
      items_sent++;
   endtask

   task wait_idle();
      req_valid <= 1'b0;
      while (center_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_reg(input logic [vpcs_pkg::CSR_IDX_W-1:0] idx, input logic [8:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         vpcs_pkg::CSR_SIZE_X: size_x_reg = data;
         vpcs_pkg::CSR_SIZE_Y: size_y_reg = data;
         vpcs_pkg::CSR_SIZE_Z: size_z_reg = data;
         vpcs_pkg::CSR_HALF_X: half_x_reg = data[2:0];
         vpcs_pkg::CSR_HALF_Y: half_y_reg = data[2:0];
         vpcs_pkg::CSR_HALF_Z: half_z_reg = data[2:0];
         vpcs_pkg::CSR_SOURCE: source_reg = data[7:0];
         default: ;
      endcase
   endtask

   task configure(input logic [8:0] sx, input logic [8:0] sy, input logic [8:0] sz,
                  input logic [8:0] hx, input logic [8:0] hy, input logic [8:0] hz,
                  input logic [8:0] src);
      write_reg(vpcs_pkg::CSR_SIZE_X, sx);
      write_reg(vpcs_pkg::CSR_SIZE_Y, sy);
      write_reg(vpcs_pkg::CSR_SIZE_Z, sz);
      write_reg(vpcs_pkg::CSR_HALF_X, hx);
      write_reg(vpcs_pkg::CSR_HALF_Y, hy);
      write_reg(vpcs_pkg::CSR_HALF_Z, hz);
      write_reg(vpcs_pkg::CSR_SOURCE, src);
      csr_valid <= 1'b0;
   endtask

   task send_volume(input int density);
      volume_done = 1'b0;
      while (!volume_done)
         send_voxel(pick_voxel(density));
   endtask

   // zero extents act as one; 1x1x1 volumes with unit patch
   task test_single_voxel();
      wait_idle();
      configure(0, 0, 0, 0, 0, 0, 8'hff);
      send_voxel(8'hff);
      send_voxel(8'h00);
      wait_idle();
      configure(0, 0, 0, 0, 0, 0, 8'h00);
      send_voxel(8'h00);
      send_voxel(8'hff);
   endtask

   task test_patch_too_big();
      wait_idle();
      configure(2, 2, 2, 1, 1, 1, 8'h5a);
      send_volume(100);
   endtask

   // widest patch on each axis; the last voxel yields center and end marker
   task test_half_extremes();
      wait_idle();
      configure(15, 1, 1, 9'h1ff, 0, 0, 8'ha5);
      send_volume(100);
      wait_idle();
      configure(1, 15, 1, 0, 7, 0, 8'h3c);
      send_volume(100);
      wait_idle();
      configure(1, 1, 15, 0, 0, 7, 8'hc3);
      send_volume(100);
   endtask

   task test_size_extremes();
      wait_idle();
      configure(256, 1, 1, $urandom_range(0, 3), 0, 0, $urandom_range(0, 255));
      send_volume(95);
      wait_idle();
      configure(9'h1ff, 1, 1, $urandom_range(0, 3), 0, 0, $urandom_range(0, 255));
      send_volume(95);
      wait_idle();
      configure(1, 300, 1, 0, $urandom_range(0, 3), 0, $urandom_range(0, 255));
      send_volume(95);
      wait_idle();
      configure(1, 1, 256, 0, 0, $urandom_range(0, 3), $urandom_range(0, 255));
      send_volume(95);
   endtask

   // register changes with the scan parked inside a volume
   task test_mid_volume_change();
      wait_idle();
      configure(8, 4, 3, 1, 1, 1, 8'h11);
      repeat (5) send_voxel(pick_voxel(100));
      wait_idle();
      configure(3, 4, 3, 0, 1, 1, 8'h22);
      send_volume(95);
      wait_idle();
      configure(4, 4, 6, 1, 1, 1, 8'h33);
      volume_done = 1'b0;
      while (pos_z != 4)
         send_voxel(pick_voxel(100));
      wait_idle();
      configure(4, 4, 3, 1, 1, 1, 8'h33);
      send_volume(100);
   endtask

   task test_back_to_back();
      wait_idle();
      idle_on = 1'b0;
      configure(6, 5, 4, 1, 1, 1, $urandom_range(0, 255));
      send_volume(100);
      send_volume(90);
      wait_idle();
      idle_on = 1'b1;
   endtask

   task test_random_volumes();
      int start;
      int density;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         wait_idle();
         idle_on = ($urandom_range(0, 4) != 0);
         configure(($urandom_range(0, 19) == 0) ? 9'd0 : 9'($urandom_range(1, 10)),
                   9'($urandom_range(1, 8)), 9'($urandom_range(1, 6)),
                   random_half_data(), random_half_data(), random_half_data(),
                   9'($urandom_range(0, 511)));
         density = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(75, 99);
         send_volume(density);
      end
      idle_on = 1'b1;
   endtask

   initial begin
      for (int i = 0; i < DIM; i++)
         column_runs[i] = 0;
      for (int i = 0; i < DIM * DIM; i++)
         plane_runs[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_single_voxel();
      test_patch_too_big();
      test_half_extremes();
      test_mid_volume_change();
      test_back_to_back();
      test_size_extremes();
      test_random_volumes();
      wait_idle();
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ valid_patch_center_scan_3d.f @@
rtl/core/vpcs_pkg.sv
rtl/core/vpcs_ram.sv
rtl/core/vpcs_scan.sv
rtl/core/vpcs_erode.sv
rtl/core/valid_patch_center_scan_3d.sv
bench/valid_patch_center_scan_3d_tb.sv
